[rtl/core/bdm_pkg.sv]
// Shared types, widths and helpers for the box diagonal min/max search.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package bdm_pkg;

	// Run length limit and derived widths
	localparam int unsigned MAX_BOXES = 65536;
	localparam int unsigned CNT_W     = $clog2(MAX_BOXES + 2);
	localparam int unsigned IDX_W     = 16;
	localparam int unsigned COORD_W   = 24;
	localparam int unsigned MAG_W     = COORD_W;
	localparam int unsigned SQ_W      = 2 * MAG_W;
	localparam int unsigned DIAG_W    = 50;
	localparam int unsigned RANK_W    = 2;

	// Rank codes
	localparam logic [RANK_W-1:0] RANK_NONE  = 2'd0;
	localparam logic [RANK_W-1:0] RANK_XY    = 2'd2;
	localparam logic [RANK_W-1:0] RANK_XYZ   = 2'd3;
	localparam logic [RANK_W-1:0] RANK_RESET = RANK_XYZ;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [DIAG_W-1:0]         diag_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [RANK_W-1:0]         rank_t;

	// Control that travels alongside each word through the pipeline
	typedef struct packed {
		logic vld;   // stage holds a word
		logic last;  // word closes the run
		logic take;  // box is non-empty and inside the index range
		logic ovf;   // run overflowed (meaningful with last)
		idx_t idx;   // box index, low bits
	} ctl_t;

	// |hi - lo| of two signed coordinates, exact in MAG_W bits
	function automatic mag_t abs_diff(input coord_t lo, input coord_t hi);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        m;
		d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
		m = d[COORD_W] ? (COORD_W+1)'(-d) : d;
		return m[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/bdm_front.sv]
// Input stage: rank register, box counter, emptiness test and per-axis
// magnitudes into the s1 register. Depends on bdm_pkg.
`default_nettype none

module bdm_front
	import bdm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   rank_we,
	input  wire rank_t  rank_wdata,
	input  wire logic   adv,
	input  wire logic   in_valid,
	input  wire coord_t lo_x,
	input  wire coord_t lo_y,
	input  wire coord_t lo_z,
	input  wire coord_t hi_x,
	input  wire coord_t hi_y,
	input  wire coord_t hi_z,
	input  wire logic   last_box,
	output ctl_t        ctl_s1,
	output mag_t        mag_x_s1,
	output mag_t        mag_y_s1,
	output mag_t        mag_z_s1
);

	rank_t rank_q;
	cnt_t  cnt_q;
	cnt_t  cnt_inc;
	logic  accept;
	logic  empty;
	logic  in_range;

	assign accept   = in_valid && adv;
	assign empty    = (rank_q == RANK_NONE) || (lo_x > hi_x);
	assign in_range = cnt_q < CNT_W'(MAX_BOXES);
	// counter saturates one past the limit
	assign cnt_inc  = (cnt_q <= CNT_W'(MAX_BOXES)) ? cnt_q + 1'b1 : cnt_q;

	// Rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RESET;
		end else if (rank_we) begin
			rank_q <= rank_wdata;
		end
	end

	// Box counter, cleared after the last word of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last_box ? '0 : cnt_inc;
		end
	end

	// s1 control; reset clears the valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= in_valid;
			ctl_s1.last <= last_box;
			ctl_s1.take <= !empty && in_range;
			ctl_s1.ovf  <= cnt_inc > CNT_W'(MAX_BOXES);
			ctl_s1.idx  <= IDX_W'(cnt_q);
		end
	end

	// s1 magnitudes; unused axes contribute zero
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s1    <= abs_diff(lo_x, hi_x);
			mag_y_s1    <= (rank_q >= RANK_XY) ? abs_diff(lo_y, hi_y) : '0;
			mag_z_s1    <= (rank_q == RANK_XYZ) ? abs_diff(lo_z, hi_z) : '0;
		end
	end

	// Assertions
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BOXES + 1))
		else $error("box counter past saturation");
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_box) |=> cnt_q == '0)
		else $error("box counter not cleared after last word");
	a_ovf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid && in_range) |=> !ctl_s1.ovf)
		else $error("overflow raised inside index range");

endmodule

`default_nettype wire

[rtl/core/bdm_square.sv]
// Squared diagonal: three squares into s2, their sum into s3.
// Depends on bdm_pkg.
`default_nettype none

module bdm_square
	import bdm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire ctl_t ctl_s1,
	input  wire mag_t mag_x_s1,
	input  wire mag_t mag_y_s1,
	input  wire mag_t mag_z_s1,
	output ctl_t      ctl_s3,
	output diag_t     diag_s3
);

	ctl_t ctl_s2;
	sq_t  sq_x_s2;
	sq_t  sq_y_s2;
	sq_t  sq_z_s2;

	// Stage control; reset clears the valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// s2: one square per axis
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s2     <= SQ_W'(mag_x_s1) * SQ_W'(mag_x_s1);
			sq_y_s2     <= SQ_W'(mag_y_s1) * SQ_W'(mag_y_s1);
			sq_z_s2     <= SQ_W'(mag_z_s1) * SQ_W'(mag_z_s1);
		end
	end

	// s3: sum of squares, exact in DIAG_W bits
	always_ff @(posedge clk) begin
		if (adv) begin
			diag_s3     <= DIAG_W'(sq_x_s2) + DIAG_W'(sq_y_s2) + DIAG_W'(sq_z_s2);
		end
	end

endmodule

`default_nettype wire

[rtl/core/bdm_track.sv]
// Running min/max tracker and result register; also produces the
// pipeline advance enable. Depends on bdm_pkg.
`default_nettype none

module bdm_track
	import bdm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ctl_t  ctl_s3,
	input  wire diag_t diag_s3,
	input  wire logic  out_stall,
	output logic       adv,
	output logic       out_valid,
	output logic       found,
	output idx_t       min_index,
	output idx_t       max_index,
	output diag_t      min_diag_sq,
	output diag_t      max_diag_sq,
	output logic       overflow
);

	logic  any_q;
	diag_t min_sq_q;
	diag_t max_sq_q;
	idx_t  min_idx_q;
	idx_t  max_idx_q;
	logic  out_valid_q;

	logic  upd;
	logic  new_min;
	logic  new_max;
	logic  any_nxt;
	diag_t min_sq_nxt;
	diag_t max_sq_nxt;
	idx_t  min_idx_nxt;
	idx_t  max_idx_nxt;
	logic  emit;

	// Only a closing word blocks while a result waits under stall
	assign adv  = !(out_valid_q && out_stall && ctl_s3.vld && ctl_s3.last);
	assign emit = adv && ctl_s3.vld && ctl_s3.last;
	assign upd  = ctl_s3.vld && ctl_s3.take;

	// Compare against the running extremes; earlier box wins ties
	assign new_min     = upd && (!any_q || (diag_s3 < min_sq_q));
	assign new_max     = upd && (!any_q || (diag_s3 > max_sq_q));
	assign any_nxt     = any_q || upd;
	assign min_sq_nxt  = new_min ? diag_s3 : min_sq_q;
	assign max_sq_nxt  = new_max ? diag_s3 : max_sq_q;
	assign min_idx_nxt = new_min ? ctl_s3.idx : min_idx_q;
	assign max_idx_nxt = new_max ? ctl_s3.idx : max_idx_q;

	// Run state, cleared when the result is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q     <= 1'b0;
			min_sq_q  <= '0;
			max_sq_q  <= '0;
			min_idx_q <= '0;
			max_idx_q <= '0;
		end else if (emit) begin
			any_q     <= 1'b0;
			min_sq_q  <= '0;
			max_sq_q  <= '0;
			min_idx_q <= '0;
			max_idx_q <= '0;
		end else if (adv) begin
			any_q     <= any_nxt;
			min_sq_q  <= min_sq_nxt;
			max_sq_q  <= max_sq_nxt;
			min_idx_q <= min_idx_nxt;
			max_idx_q <= max_idx_nxt;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			found       <= any_nxt;
			min_index   <= min_idx_nxt;
			max_index   <= max_idx_nxt;
			min_diag_sq <= min_sq_nxt;
			max_diag_sq <= max_sq_nxt;
			overflow    <= ctl_s3.ovf;
		end
	end

	assign out_valid = out_valid_q;

	// Assertions
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (min_sq_q == '0 && max_sq_q == '0 && min_idx_q == '0 && max_idx_q == '0))
		else $error("run state not zero while nothing found");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> min_sq_q <= max_sq_q)
		else $error("running minimum above running maximum");
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(ctl_s3.vld && ctl_s3.last))
		else $error("result produced without a closing word");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found) |-> (min_diag_sq == '0 && max_diag_sq == '0))
		else $error("empty run reported nonzero diagonal");

endmodule

`default_nettype wire

[rtl/core/box_diagonal_min_max_search.sv]
// Top level of the box diagonal min/max search.
// Instantiates bdm_front, bdm_square and bdm_track; depends on bdm_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall): one box per word, lower and upper
//    corner plus last_box. A word is taken on a clock edge with in_valid
//    high and in_stall low.
//  - Output channel (out_valid/out_stall): one result word per run, on the
//    word marked last_box; taken with out_valid high and out_stall low.
//  - rank_we/rank_wdata write the rank register (dimensions in use); write
//    it only while no run is in flight.
//  - Throughput: one box per cycle while in_stall is low. The path is input register
//    (differences), square register, sum register, then the running
//    min/max compare, which loads the result register.
//  - While a result waits under out_stall the pipeline keeps taking boxes;
//    only the next closing word holds at the compare stage, and in_stall
//    rises until the waiting result is taken.
//  - Reset (arst_n low) clears the run state and valid bits and sets rank
//    to three dimensions.
`default_nettype none

module box_diagonal_min_max_search
	import bdm_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   rank_we,
	input  wire rank_t  rank_wdata,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire coord_t lo_x,
	input  wire coord_t lo_y,
	input  wire coord_t lo_z,
	input  wire coord_t hi_x,
	input  wire coord_t hi_y,
	input  wire coord_t hi_z,
	input  wire logic   last_box,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic        found,
	output idx_t        min_index,
	output idx_t        max_index,
	output diag_t       min_diag_sq,
	output diag_t       max_diag_sq,
	output logic        overflow
);

	logic  adv;
	ctl_t  ctl_s1;
	ctl_t  ctl_s3;
	mag_t  mag_x_s1;
	mag_t  mag_y_s1;
	mag_t  mag_z_s1;
	diag_t diag_s3;

	assign in_stall = !adv;

	// Input register and counter
	bdm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rank_we    (rank_we),
		.rank_wdata (rank_wdata),
		.adv        (adv),
		.in_valid   (in_valid),
		.lo_x       (lo_x),
		.lo_y       (lo_y),
		.lo_z       (lo_z),
		.hi_x       (hi_x),
		.hi_y       (hi_y),
		.hi_z       (hi_z),
		.last_box   (last_box),
		.ctl_s1     (ctl_s1),
		.mag_x_s1   (mag_x_s1),
		.mag_y_s1   (mag_y_s1),
		.mag_z_s1   (mag_z_s1)
	);

	// Squared diagonal
	bdm_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.mag_x_s1 (mag_x_s1),
		.mag_y_s1 (mag_y_s1),
		.mag_z_s1 (mag_z_s1),
		.ctl_s3   (ctl_s3),
		.diag_s3  (diag_s3)
	);

	// Running extremes and result register
	bdm_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s3      (ctl_s3),
		.diag_s3     (diag_s3),
		.out_stall   (out_stall),
		.adv         (adv),
		.out_valid   (out_valid),
		.found       (found),
		.min_index   (min_index),
		.max_index   (max_index),
		.min_diag_sq (min_diag_sq),
		.max_diag_sq (max_diag_sq),
		.overflow    (overflow)
	);

endmodule

`default_nettype wire

[test/box_diagonal_min_max_search_tb.sv]
// Self-checking testbench for box_diagonal_min_max_search: directed table, then random runs.
// Each result word is checked against the table's expected word or a built-in min/max diagonal tracker.
// Depends on bdm_pkg and the box_diagonal_min_max_search RTL.

module box_diagonal_min_max_search_tb;
	import bdm_pkg::*;

	localparam rank_t       RANK_X       = 2'd1;
	localparam coord_t      C_MIN        = coord_t'(-8388608);
	localparam coord_t      C_MAX        = coord_t'(8388607);
	localparam diag_t       FULL_SQ      = 50'd844424829468675;
	localparam int          NDIR         = 14;
	localparam int unsigned PHASE_BOXES  = 280;
	localparam int unsigned OVF_RUN      = MAX_BOXES + 4;
	localparam int          DRAIN_CYCLES = 10;

	typedef struct packed {
		coord_t lo_x;
		coord_t lo_y;
		coord_t lo_z;
		coord_t hi_x;
		coord_t hi_y;
		coord_t hi_z;
		logic   last;
	} box_t;

	typedef struct packed {
		logic  found;
		idx_t  min_index;
		idx_t  max_index;
		diag_t min_diag_sq;
		diag_t max_diag_sq;
		logic  overflow;
	} diag_res_t;

	typedef struct packed {
		box_t      box;
		logic      typed;
		diag_res_t want;
	} dir_row_t;

	// DUT signals
	logic   clk;
	logic   arst_n = 1'b0;
	logic   rank_we = 1'b0;
	rank_t  rank_wdata = RANK_RESET;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t lo_x = '0, lo_y = '0, lo_z = '0;
	coord_t hi_x = '0, hi_y = '0, hi_z = '0;
	logic   last_box = 1'b0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   found;
	idx_t   min_index, max_index;
	diag_t  min_diag_sq, max_diag_sq;
	logic   overflow;

	// Directed words, all at rank three; expected words typed on the obvious rows
	dir_row_t dir_rows [NDIR] = '{
		// empty box alone, marked last
		'{'{1, 0, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b0, 16'd0, 16'd0, 50'd0, 50'd0, 1'b0}},
		// zero-size box
		'{'{0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, 16'd0, 16'd0, 50'd0, 50'd0, 1'b0}},
		// full-range box
		'{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1}, 1'b1,
			'{1'b1, 16'd0, 16'd0, FULL_SQ, FULL_SQ, 1'b0}},
		// full box, inverted x (empty), zero box
		'{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0}, 1'b0, '0},
		'{'{C_MAX, 0, 0, C_MIN, 0, 0, 1'b0}, 1'b0, '0},
		'{'{0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, 16'd2, 16'd0, 50'd0, FULL_SQ, 1'b0}},
		// tie: earlier box kept on both sides
		'{'{0, 0, 0, 3, 3, 3, 1'b0}, 1'b0, '0},
		'{'{0, 0, 0, 3, 3, 3, 1'b1}, 1'b1, '{1'b1, 16'd0, 16'd0, 50'd27, 50'd27, 1'b0}},
		// negative corners, inverted y/z do not make a box empty
		'{'{-5, -5, -5, -2, -1, 0, 1'b0}, 1'b0, '0},
		'{'{-1, C_MAX, C_MIN, -1, C_MIN, C_MAX, 1'b0}, 1'b0, '0},
		'{'{C_MAX, -7, 100, C_MAX, 7, -100, 1'b1}, 1'b0, '0},
		'{'{0, 100, -100, 0, -100, 100, 1'b1}, 1'b1,
			'{1'b1, 16'd0, 16'd0, 50'd80000, 50'd80000, 1'b0}},
		// x lower by one, then x upper by one (empty)
		'{'{-1, 0, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, 16'd0, 16'd0, 50'd1, 50'd1, 1'b0}},
		'{'{0, 0, 0, -1, 0, 0, 1'b1}, 1'b1, '{1'b0, 16'd0, 16'd0, 50'd0, 50'd0, 1'b0}}
	};

	// Tracker state
	rank_t       cur_rank = RANK_RESET;
	int unsigned run_boxes = 0;
	diag_t       best_min_sq = '0, best_max_sq = '0;
	int unsigned best_min_idx = 0, best_max_idx = 0;
	bit          seen_box = 1'b0;

	diag_res_t   expected_results [$];
	int          err_count = 0;
	int          burst_left = 0;
	int          stall_kind = 0;
	int          stall_span = 0;

	box_diagonal_min_max_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rank_we     (rank_we),
		.rank_wdata  (rank_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.lo_x        (lo_x),
		.lo_y        (lo_y),
		.lo_z        (lo_z),
		.hi_x        (hi_x),
		.hi_y        (hi_y),
		.hi_z        (hi_z),
		.last_box    (last_box),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.min_index   (min_index),
		.max_index   (max_index),
		.min_diag_sq (min_diag_sq),
		.max_diag_sq (max_diag_sq),
		.overflow    (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop
	initial begin
		#15000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic diag_t axis_sq(input coord_t lo, input coord_t hi);
		longint d;
		d = longint'($signed(hi)) - longint'($signed(lo));
		return diag_t'(d * d);
	endfunction

	// Advance the running min/max by one box; returns the word a closing box emits
	task automatic track_box(input box_t b, output bit emits, output diag_res_t r);
		diag_t       dsq;
		int unsigned idx;
		idx = run_boxes;
		if (run_boxes <= MAX_BOXES)
			run_boxes++;
		if (cur_rank != RANK_NONE && !($signed(b.lo_x) > $signed(b.hi_x)) && idx < MAX_BOXES) begin
			dsq = axis_sq(b.lo_x, b.hi_x);
			if (cur_rank >= RANK_XY)
				dsq += axis_sq(b.lo_y, b.hi_y);
			if (cur_rank == RANK_XYZ)
				dsq += axis_sq(b.lo_z, b.hi_z);
			if (!seen_box) begin
				best_min_sq  = dsq;
				best_max_sq  = dsq;
				best_min_idx = idx;
				best_max_idx = idx;
				seen_box     = 1'b1;
			end else begin
				if (dsq < best_min_sq) begin
					best_min_sq  = dsq;
					best_min_idx = idx;
				end
				if (dsq > best_max_sq) begin
					best_max_sq  = dsq;
					best_max_idx = idx;
				end
			end
		end
		emits = b.last;
		r = '0;
		if (b.last) begin
			if (seen_box) begin
				r.found       = 1'b1;
				r.min_index   = idx_t'(best_min_idx);
				r.max_index   = idx_t'(best_max_idx);
				r.min_diag_sq = best_min_sq;
				r.max_diag_sq = best_max_sq;
			end
			r.overflow   = (run_boxes > MAX_BOXES);
			run_boxes    = 0;
			best_min_sq  = '0;
			best_max_sq  = '0;
			best_min_idx = 0;
			best_max_idx = 0;
			seen_box     = 1'b0;
		end
	endtask

	function automatic coord_t rand_coord(input int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 6)) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: return C_MIN;
					1: return C_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Mostly non-empty boxes; small coordinates give frequent ties
	function automatic box_t rand_box();
		box_t   b;
		coord_t t;
		int     kind;
		kind   = ($urandom_range(0, 5) < 3) ? 0 : ($urandom_range(0, 2) != 0 ? 1 : 2);
		b.lo_x = rand_coord(kind);
		b.lo_y = rand_coord(kind);
		b.lo_z = rand_coord(kind);
		b.hi_x = rand_coord(kind);
		b.hi_y = rand_coord(kind);
		b.hi_z = rand_coord(kind);
		b.last = 1'b0;
		if ($signed(b.lo_x) > $signed(b.hi_x) && $urandom_range(0, 4) != 0) begin
			t      = b.lo_x;
			b.lo_x = b.hi_x;
			b.hi_x = t;
		end
		return b;
	endfunction

	// Drive one word and hold it until taken; paced words follow the burst/gap pattern
	task automatic send_box(input box_t b, input bit paced, input bit typed, input diag_res_t want);
		bit        emits;
		diag_res_t r;
		if (paced) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		lo_x     <= b.lo_x;
		lo_y     <= b.lo_y;
		lo_z     <= b.lo_z;
		hi_x     <= b.hi_x;
		hi_y     <= b.hi_y;
		hi_z     <= b.hi_z;
		last_box <= b.last;
		do @(posedge clk); while (in_stall);
		track_box(b, emits, r);
		if (emits)
			expected_results.push_back(typed ? want : r);
	endtask

	// Rank changes only with nothing in flight
	task automatic write_rank(input rank_t r);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		rank_we    <= 1'b1;
		rank_wdata <= r;
		@(posedge clk);
		rank_we  <= 1'b0;
		cur_rank = r;
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("word with nothing pending", 1, 0);
			end else begin
				if (found !== expected_results[0].found)
					report_mismatch("found", found, expected_results[0].found);
				if (min_index !== expected_results[0].min_index)
					report_mismatch("min_index", min_index, expected_results[0].min_index);
				if (max_index !== expected_results[0].max_index)
					report_mismatch("max_index", max_index, expected_results[0].max_index);
				if (min_diag_sq !== expected_results[0].min_diag_sq)
					report_mismatch("min_diag_sq", min_diag_sq, expected_results[0].min_diag_sq);
				if (max_diag_sq !== expected_results[0].max_diag_sq)
					report_mismatch("max_diag_sq", max_diag_sq, expected_results[0].max_diag_sq);
				if (overflow !== expected_results[0].overflow)
					report_mismatch("overflow", overflow, expected_results[0].overflow);
				void'(expected_results.pop_front());
			end
		end
		if (stall_span == 0) begin
			stall_kind <= $urandom_range(0, 2);
			stall_span <= $urandom_range(20, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_kind)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) != 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Stimulus
	initial begin
		rank_t       phase_ranks [7];
		int unsigned phase_left;
		int unsigned run_len;
		box_t        b;
		phase_ranks = '{RANK_X, RANK_NONE, RANK_XY, RANK_XYZ, RANK_X, RANK_XY, RANK_XYZ};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NDIR; i++)
			send_box(dir_rows[i].box, 1'b1, dir_rows[i].typed, dir_rows[i].want);

		// Random runs at each rank
		foreach (phase_ranks[p]) begin
			write_rank(phase_ranks[p]);
			phase_left = PHASE_BOXES;
			while (phase_left != 0) begin
				run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
				if (run_len > phase_left)
					run_len = phase_left;
				for (int k = 0; k < run_len; k++) begin
					b      = rand_box();
					b.last = (k == run_len - 1);
					send_box(b, 1'b1, 1'b0, '0);
				end
				phase_left -= run_len;
			end
		end

		// One run past the index range; boxes beyond it alternate huge and zero-size
		for (int unsigned k = 0; k < OVF_RUN; k++) begin
			b = rand_box();
			if (k >= MAX_BOXES)
				b = (k % 2 == 0) ? box_t'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0}
					: box_t'(0);
			b.last = (k == OVF_RUN - 1);
			send_box(b, 1'b0, 1'b0, '0);
		end

		// Short run after overflow: state must have cleared
		for (int k = 0; k < 5; k++) begin
			b      = rand_box();
			b.last = (k == 4);
			send_box(b, 1'b1, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
